### rtl/psr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_pkg: shared types and constants for the pitch snap retune block
// item structs, register indexes, scale masks and fixed-point constants
// ----------------------------------------------------------------------------
package psr_pkg;

  localparam int unsigned NUM_SCALES = 5;

  typedef enum logic [1:0] {
    REG_SCALE  = 2'd0,
    REG_RETUNE = 2'd1,
    REG_GATE   = 2'd2
  } reg_idx_e;

  localparam logic [15:0] HZ_LO_Q4     = 16'd960;
  localparam logic [15:0] HZ_HI_Q4     = 16'd17600;
  localparam logic [22:0] MIDI_OFS_Q16 = 23'd5529686;
  localparam logic [22:0] NOTE_LO_Q16  = 23'(45 * 65536);
  localparam logic [22:0] NOTE_HI_Q16  = 23'(81 * 65536);
  localparam logic [16:0] ATTACK_Q16   = 17'd26214;
  localparam logic [16:0] RELEASE_Q16  = 17'd7864;
  localparam logic [10:0] VOL_MAX      = 11'd1792;
  localparam logic [10:0] AUDIBLE_MIN  = 11'd26;
  localparam logic [14:0] PITCH_RESET  = 15'd15360;
  localparam int unsigned SLEW_BASE    = 7864;
  localparam int unsigned SLEW_SPAN    = 57672;

  typedef struct packed {
    logic        mic_on;
    logic [15:0] pitch_hz;
    logic [15:0] level;
  } in_item_t;

  typedef struct packed {
    logic [14:0] carrier_pitch;
    logic [10:0] carrier_volume;
    logic [14:0] target_pitch;
    logic [14:0] raw_pitch;
    logic        voiced;
    logic        audible;
  } out_item_t;

  // classified item between front and back
  typedef struct packed {
    logic        mic_on;
    logic        voiced;
    logic [15:0] pitch_hz;
    logic [15:0] level;
  } cls_item_t;

  // slew factor for every retune knob position
  typedef logic [255:0][16:0] slew_tab_t;

  function automatic slew_tab_t slew_table();
    slew_tab_t       t;
    longint unsigned v;
    t = '0;
    for (int r = 0; r < 256; r++) begin
      v = (64'(SLEW_BASE) * 64'd65025 + 64'(SLEW_SPAN) * 64'(r) * 64'(r) + 64'd32512)
          / 64'd65025;
      t[r] = 17'(v);
    end
    return t;
  endfunction

  localparam slew_tab_t SLEW_TAB = slew_table();

  function automatic logic [11:0] scale_mask(input logic [2:0] sel);
    logic [11:0] m;
    m = 12'hFFF;
    if (32'(sel) >= NUM_SCALES) m = 12'h295;
    else begin
      case (sel)
        3'd0: m = 12'h295;
        3'd1: m = 12'h4A9;
        3'd2: m = 12'hAB5;
        3'd3: m = 12'h5AD;
        default: m = 12'hFFF;
      endcase
    end
    return m;
  endfunction

endpackage

### rtl/psr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_front: input stage
// takes items, applies the gate and frequency window, queues them (depth 2)
// ----------------------------------------------------------------------------
module psr_front import psr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    item_i,
  input  logic [15:0] gate_i,
  output logic        q_valid_o,
  output cls_item_t   q_item_o,
  input  logic        q_take_i
);

  cls_item_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cls_item_t  cls;

  always_comb begin
    cls.mic_on   = item_i.mic_on;
    cls.pitch_hz = item_i.pitch_hz;
    cls.level    = item_i.level;
    cls.voiced   = item_i.mic_on && (item_i.level > gate_i) &&
                   (item_i.pitch_hz > HZ_LO_Q4) && (item_i.pitch_hz < HZ_HI_Q4);
  end

  assign full      = (cnt_q == 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push && !full) mem_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push && !full) wr_q <= ~wr_q;
      if (q_take_i && q_valid_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push && !full) - 2'(q_take_i && q_valid_o);
    end
  end

endmodule

### rtl/psr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_back: sequencer that carries out one classified item
// log2 by squaring, midi mapping, scale snap, pitch and volume slew
// ----------------------------------------------------------------------------
module psr_back import psr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  cls_item_t   in_item_i,
  output logic        in_take_o,
  input  logic [2:0]  scale_i,
  input  logic [7:0]  retune_i,
  output logic        out_valid_o,
  output out_item_t   out_item_o,
  input  logic        out_take_i
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_LOG   = 10'b0000000010,
    ST_MIDI  = 10'b0000000100,
    ST_SNAP  = 10'b0000001000,
    ST_SLEWA = 10'b0000010000,
    ST_SLEWB = 10'b0000100000,
    ST_SLEWC = 10'b0001000000,
    ST_SLEWD = 10'b0010000000,
    ST_DONE  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  state_e      st_q;
  cls_item_t   it_q;
  logic [3:0]  e_q;
  logic [16:0] m_q;
  logic [15:0] frac_q;
  logic [4:0]  bit_q;
  logic [14:0] raw_q;
  logic [6:0]  note_q, best_q;
  logic [14:0] bestd_q;
  logic [3:0]  pc_q;
  logic [14:0] cur_q, tgt_q;
  logic [10:0] vol_q, tvol_q;
  logic        seen_q;
  logic [16:0] sf_q;
  logic [31:0] prod_q;
  logic        dir_q;
  out_item_t   out_q;

  // msb search over the input
  logic [3:0] e_w;
  always_comb begin
    e_w = 4'd0;
    for (int i = 1; i < 16; i++) if (it_q.pitch_hz[i]) e_w = 4'(i);
  end

  logic [33:0] sq;
  logic [16:0] msq;
  assign sq  = 34'(m_q) * 34'(m_q);
  assign msq = 17'(sq >> 15);

  // slew factor looked up by knob position
  logic [16:0] sfac;
  assign sfac = SLEW_TAB[retune_i];

  logic [27:0] l12;
  logic signed [29:0] midi;
  logic [22:0] mclamp;
  always_comb begin
    l12  = 28'({e_q, frac_q}) * 28'd12;
    midi = 30'(signed'({2'b0, l12})) - 30'(signed'({7'b0, MIDI_OFS_Q16}));
    if (midi < 30'(signed'({7'b0, NOTE_LO_Q16}))) mclamp = NOTE_LO_Q16;
    else if (midi > 30'(signed'({7'b0, NOTE_HI_Q16}))) mclamp = NOTE_HI_Q16;
    else mclamp = 23'(midi);
  end

  logic [14:0] cand, cdist;
  logic [11:0] mask;
  assign cand  = {note_q, 8'd0};
  assign cdist = (cand > raw_q) ? cand - raw_q : raw_q - cand;
  assign mask  = scale_mask(scale_i);

  // shared slew multiplier
  logic [14:0] sx, st, sd;
  logic [16:0] sfm;
  logic [32:0] sprod;
  logic [16:0] step;
  always_comb begin
    if (st_q == ST_SLEWA || st_q == ST_SLEWB) begin
      sx = cur_q; st = tgt_q; sfm = sf_q;
    end else begin
      sx = {4'd0, vol_q}; st = {4'd0, tvol_q};
      sfm = (tvol_q > vol_q) ? ATTACK_Q16 : RELEASE_Q16;
    end
    sd    = (st >= sx) ? st - sx : sx - st;
    sprod = 33'(sd) * 33'(sfm);
    step  = 17'((33'(prod_q) + 33'd65535) >> 16);
  end

  logic [10:0] tv_w;
  logic [20:0] tv24;
  always_comb begin
    tv24 = (21'(it_q.level) * 21'd24 + 21'd128) >> 8;
    tv_w = (tv24 > 21'(VOL_MAX)) ? VOL_MAX : 11'(tv24);
  end

  assign in_take_o   = (st_q == ST_IDLE) && in_valid_i;
  assign out_valid_o = (st_q == ST_OUT);
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        it_q   <= in_item_i;
        frac_q <= 16'd0;
        bit_q  <= 5'd0;
        raw_q  <= 15'd0;
        sf_q   <= sfac;
      end
      ST_LOG: begin
        if (bit_q == 5'd0) begin
          e_q <= e_w;
          m_q <= 17'(({16'd0, it_q.pitch_hz} << (4'd15 - e_w)) & 32'hFFFF);
          bit_q <= 5'd1;
        end else begin
          if (msq[16]) begin
            m_q <= msq >> 1; frac_q <= {frac_q[14:0], 1'b1};
          end else begin
            m_q <= msq; frac_q <= {frac_q[14:0], 1'b0};
          end
          bit_q <= bit_q + 5'd1;
        end
      end
      ST_MIDI: begin
        raw_q   <= 15'((24'(mclamp) + 24'd128) >> 8);
        note_q  <= 7'd0;
        pc_q    <= 4'd0;
        bestd_q <= 15'h7FFF;
        best_q  <= 7'd0;
      end
      ST_SNAP: begin
        if (mask[pc_q] && ({1'b0, cdist} < {1'b0, bestd_q} || bestd_q == 15'h7FFF &&
            cdist != 15'h7FFF)) begin
          bestd_q <= cdist;
          best_q  <= note_q;
        end
        note_q <= note_q + 7'd1;
        pc_q   <= (pc_q == 4'd11) ? 4'd0 : pc_q + 4'd1;
      end
      ST_SLEWA, ST_SLEWC: begin
        prod_q <= 32'(sprod);
        dir_q  <= (st >= sx);
      end
      ST_DONE: begin
        out_q.carrier_pitch  <= cur_q;
        out_q.carrier_volume <= vol_q;
        out_q.target_pitch   <= tgt_q;
        out_q.raw_pitch      <= raw_q;
        out_q.voiced         <= it_q.voiced;
        out_q.audible        <= (vol_q >= AUDIBLE_MIN);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cur_q  <= PITCH_RESET;
      tgt_q  <= PITCH_RESET;
      vol_q  <= 11'd0;
      tvol_q <= 11'd0;
      seen_q <= 1'b0;
    end else begin
      case (st_q)
        ST_IDLE: if (in_valid_i) begin
          if (!in_item_i.mic_on) begin
            vol_q <= 11'd0;
            st_q  <= ST_DONE;
          end else if (in_item_i.voiced) st_q <= ST_LOG;
          else begin
            tvol_q <= 11'd0;
            st_q   <= ST_SLEWA;
          end
        end
        ST_LOG:  if (bit_q == 5'd16) st_q <= ST_MIDI;
        ST_MIDI: st_q <= ST_SNAP;
        ST_SNAP: if (note_q == 7'd107) begin
          // final candidate folded in here
          if (mask[pc_q] && cdist < bestd_q) begin
            tgt_q <= {best_q, 8'd0} == cand ? cand : {note_q, 8'd0};
            if (!seen_q) cur_q <= {note_q, 8'd0};
          end else begin
            tgt_q <= {best_q, 8'd0};
            if (!seen_q) cur_q <= {best_q, 8'd0};
          end
          seen_q <= 1'b1;
          tvol_q <= tv_w;
          st_q   <= ST_SLEWA;
        end
        ST_SLEWA: st_q <= ST_SLEWB;
        ST_SLEWB: begin
          cur_q <= dir_q ? cur_q + 15'(step) : cur_q - 15'(step);
          st_q  <= ST_SLEWC;
        end
        ST_SLEWC: st_q <= ST_SLEWD;
        ST_SLEWD: begin
          vol_q <= dir_q ? vol_q + 11'(step) : vol_q - 11'(step);
          st_q  <= ST_DONE;
        end
        ST_DONE:  st_q <= ST_OUT;
        ST_OUT:   if (out_take_i) st_q <= ST_IDLE;
        default:  st_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/pitch_snap_retune.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_snap_retune: scale-snapping pitch corrector with retune slew
// a voiced item runs 17 log2 steps and 108 snap steps before the slew steps, an unvoiced
// item goes straight to the slew steps and a muted one straight to the result
// one item in flight: the back end takes the next item only after the result is popped
// reset: asynchronous active low, registers to defaults, pitch state to note 60
// ----------------------------------------------------------------------------
module pitch_snap_retune import psr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [2:0]  scale_q;
  logic [7:0]  retune_q;
  logic [15:0] gate_q;
  logic        qv, take, ov;
  cls_item_t   qi;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= 3'd0;
      retune_q <= 8'd255;
      gate_q   <= 16'd786;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SCALE:  scale_q  <= cfg_data_i[2:0];
        REG_RETUNE: retune_q <= cfg_data_i[7:0];
        REG_GATE:   gate_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  psr_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .item_i(in_item_i), .gate_i(gate_q),
    .q_valid_o(qv), .q_item_o(qi), .q_take_i(take)
  );

  psr_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(qv), .in_item_i(qi), .in_take_o(take),
    .scale_i(scale_q), .retune_i(retune_q),
    .out_valid_o(ov), .out_item_o(out_item_o), .out_take_i(pop)
  );

  assign empty = !ov;

endmodule

### bench/psr_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psr_frame_checker: predicts and checks pitch snap retune results
// watches the item, result and register channels, keeps its own copy of the
// pitch, target and volume state, and compares each popped result field by
// field with the oldest predicted frame
// ----------------------------------------------------------------------------
module psr_frame_checker import psr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  in_item_t    in_item_i,
  input  logic        empty,
  input  logic        pop,
  input  out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          mismatch_count_o,
  output int          frames_waiting_o
);

  // pitch-class masks by raw selector, out-of-range selectors fall back to major penta
  localparam logic [11:0] SCALE_MASKS [8] = '{
    12'h295, 12'h4A9, 12'hAB5, 12'h5AD, 12'hFFF, 12'h295, 12'h295, 12'h295
  };

  logic [2:0]  scale_sel;
  logic [7:0]  retune_knob;
  logic [15:0] gate_thr;
  int unsigned cur_pitch;
  int unsigned tgt_note;
  int unsigned vol_level;
  bit          tgt_seen;
  out_item_t   expected_frames [$];

  assign frames_waiting_o = expected_frames.size();

  function automatic int unsigned log2_hz(int unsigned v);
    int unsigned e;
    int unsigned m;
    int unsigned frac;
    e = 0;
    frac = 0;
    while (e < 15 && (v >> (e + 1)) != 0) e++;
    m = (v << (15 - e)) & 32'hFFFF;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 15;
      frac = frac << 1;
      if (m >= 65536) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (e << 16) | frac;
  endfunction

  function automatic int unsigned step_toward(int unsigned x, int unsigned t,
                                              int unsigned f);
    longint unsigned d;
    if (t >= x) begin
      d = t - x;
      return x + int'((d * f + 65535) >> 16);
    end
    d = x - t;
    return x - int'((d * f + 65535) >> 16);
  endfunction

  function automatic int unsigned snap_to_scale(int unsigned raw, logic [11:0] mask);
    int unsigned best;
    int unsigned bestd;
    int unsigned d;
    best = raw >> 8;
    bestd = 32'hFFFF_FFFF;
    for (int unsigned n = 0; n < 108; n++) begin
      if (mask[n % 12]) begin
        d = ((n << 8) > raw) ? (n << 8) - raw : raw - (n << 8);
        if (d < bestd) begin
          bestd = d;
          best = n;
        end
      end
    end
    return best << 8;
  endfunction

  function automatic out_item_t predict_frame(in_item_t x);
    out_item_t r;
    longint    midi;
    int unsigned raw;
    int unsigned slew_f;
    int unsigned tvol;
    bit        voiced;
    raw = 0;
    voiced = 0;
    if (!x.mic_on) begin
      vol_level = 0;
    end else begin
      voiced = (x.level > gate_thr) && (x.pitch_hz > 960) && (x.pitch_hz < 17600);
      if (voiced) begin
        midi = 12 * longint'(log2_hz(x.pitch_hz)) - 5529686;
        if (midi < 45 * 65536) midi = 45 * 65536;
        if (midi > 81 * 65536) midi = 81 * 65536;
        raw = int'((midi + 128) >> 8);
        tgt_note = snap_to_scale(raw, SCALE_MASKS[scale_sel]);
        if (!tgt_seen) begin
          cur_pitch = tgt_note;
          tgt_seen = 1;
        end
      end
      slew_f = int'((64'd7864 * 65025 + 64'd57672 * retune_knob * retune_knob + 32512)
                    / 65025);
      cur_pitch = step_toward(cur_pitch, tgt_note, slew_f);
      tvol = voiced ? (24 * int'(x.level) + 128) >> 8 : 0;
      if (tvol > 1792) tvol = 1792;
      vol_level = step_toward(vol_level, tvol, (tvol > vol_level) ? 26214 : 7864);
    end
    r.carrier_pitch  = 15'(cur_pitch);
    r.carrier_volume = 11'(vol_level);
    r.target_pitch   = 15'(tgt_note);
    r.raw_pitch      = 15'(raw);
    r.voiced         = voiced;
    r.audible        = (vol_level >= 26);
    return r;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d got %0d", name, exp_v, act_v);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      scale_sel = 3'd0;
      retune_knob = 8'd255;
      gate_thr = 16'd786;
      cur_pitch = 15360;
      tgt_note = 15360;
      vol_level = 0;
      tgt_seen = 0;
      expected_frames.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SCALE:  scale_sel = cfg_data_i[2:0];
          REG_RETUNE: retune_knob = cfg_data_i[7:0];
          REG_GATE:   gate_thr = cfg_data_i;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_frames.size() == 0) begin
          $error("result popped with no item outstanding");
          mismatch_count_o++;
        end else begin
          exp_r = expected_frames.pop_front();
          check_field("carrier_pitch", exp_r.carrier_pitch, out_item_o.carrier_pitch);
          check_field("carrier_volume", exp_r.carrier_volume, out_item_o.carrier_volume);
          check_field("target_pitch", exp_r.target_pitch, out_item_o.target_pitch);
          check_field("raw_pitch", exp_r.raw_pitch, out_item_o.raw_pitch);
          check_field("voiced", exp_r.voiced, out_item_o.voiced);
          check_field("audible", exp_r.audible, out_item_o.audible);
        end
      end
      if (push && !full) expected_frames.push_back(predict_frame(in_item_i));
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for pitch_snap_retune
// directed frames at the window edges and mute, then phases of random frames
// under several scale, retune and gate settings with bursty pushes and
// patterned pop stalls; checking is done by psr_frame_checker
// ----------------------------------------------------------------------------
module tb;
  import psr_pkg::*;

  localparam int          IDLE_LIMIT = 5000;
  localparam logic [1:0]  REG_UNUSED = 2'd3;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        push = 0;
  logic        full;
  in_item_t    in_item_i = '0;
  logic        empty;
  logic        pop = 0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  int          mismatches;
  int          frames_waiting;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          stall_timer = 0;
  logic [15:0] cur_gate = 16'd786;

  always #4 clk_i = ~clk_i;

  pitch_snap_retune dut (.*);

  psr_frame_checker checker_i (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .mismatch_count_o(mismatches), .frames_waiting_o(frames_waiting)
  );

  // pop pattern: free running, coin flip, or mostly stalled
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (stall_timer == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_timer <= $urandom_range(20, 150);
      end else begin
        stall_timer <= stall_timer - 1;
      end
      case (stall_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        default: pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_frame(input in_item_t x);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    push <= 1'b1;
    in_item_i <= x;
    do @(posedge clk_i); while (full);
    burst_left--;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (frames_waiting != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_item_t frame(logic mic, logic [15:0] hz, logic [15:0] lvl);
    in_item_t x;
    x.mic_on = mic;
    x.pitch_hz = hz;
    x.level = lvl;
    return x;
  endfunction

  function automatic in_item_t random_frame(logic [15:0] gate);
    int unsigned kind;
    in_item_t x;
    kind = $urandom_range(0, 19);
    x.mic_on = (kind != 0);
    x.pitch_hz = (kind < 3) ? 16'($urandom) : 16'($urandom_range(961, 17599));
    if (kind < 5 || gate == 16'hFFFF) x.level = 16'($urandom);
    else x.level = 16'($urandom_range(int'(gate) + 1, 65535));
    return x;
  endfunction

  initial begin
    logic [2:0]  phase_scale [6] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd7};
    logic [7:0]  phase_retune [6] = '{8'd255, 8'd0, 8'd128, 8'd255, 8'd37, 8'd200};
    logic [15:0] phase_gate [6] = '{16'd786, 16'd0, 16'd5000, 16'hFFFF, 16'd300, 16'd12000};
    in_item_t    directed [$];

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // mute and unvoiced frames before the first voiced one, then a mix of voiced, unvoiced and mute frames
    directed.push_back(frame(1'b0, 16'd7040, 16'hFFFF));
    directed.push_back(frame(1'b1, 16'd7040, 16'd786));
    directed.push_back(frame(1'b1, 16'd960, 16'hFFFF));
    directed.push_back(frame(1'b1, 16'd0, 16'd0));
    directed.push_back(frame(1'b1, 16'd961, 16'd787));
    directed.push_back(frame(1'b1, 16'd17599, 16'hFFFF));
    directed.push_back(frame(1'b1, 16'd17600, 16'hFFFF));
    directed.push_back(frame(1'b1, 16'hFFFF, 16'hFFFF));
    directed.push_back(frame(1'b1, 16'd7040, 16'hFFFF));
    directed.push_back(frame(1'b1, 16'd7040, 16'hFFFF));
    directed.push_back(frame(1'b1, 16'd3520, 16'd20000));
    directed.push_back(frame(1'b1, 16'd1600, 16'd8000));
    directed.push_back(frame(1'b1, 16'd4662, 16'd3000));
    directed.push_back(frame(1'b1, 16'd12000, 16'd40000));
    directed.push_back(frame(1'b1, 16'd7040, 16'd0));
    directed.push_back(frame(1'b0, 16'hFFFF, 16'hFFFF));
    directed.push_back(frame(1'b1, 16'd1000, 16'hFFFF));
    directed.push_back(frame(1'b1, 16'd16000, 16'd1000));
    foreach (directed[i]) send_frame(directed[i]);
    drain_results();

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain_results();
        write_reg(REG_SCALE, {13'($urandom), phase_scale[p]});
        write_reg(REG_RETUNE, {8'($urandom), phase_retune[p]});
        write_reg(REG_GATE, phase_gate[p]);
        write_reg(REG_UNUSED, 16'($urandom));
        cur_gate = phase_gate[p];
      end
      repeat (100) send_frame(random_frame(cur_gate));
    end

    drain_results();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
